// ===== sv/lbs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the skinning block.
// Used by linear_blend_vertex_skinning and by its testbench.
`timescale 1ns / 1ps

package lbs_pkg;

  // Field and datapath widths.
  localparam int unsigned BoneW   = 6;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned AccW    = 50;
  localparam int unsigned DivNW   = 50;
  localparam int unsigned DivDW   = 32;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned WsumW   = 17;
  localparam int unsigned SqW     = 63;

  // Opcodes of an input request.
  localparam logic OpLoad = 1'b0;
  localparam logic OpSkin = 1'b1;

  // Fixed-point constants.
  localparam logic signed [AccW-1:0] OneQ16   = AccW'(65536);
  localparam logic [WsumW-1:0]       OneQ15   = WsumW'(32768);
  localparam logic [WsumW-1:0]       NearLo   = WsumW'(32765);
  localparam logic [WsumW-1:0]       NearHi   = WsumW'(32771);
  localparam logic [DivNW-1:0]       NrmCap   = DivNW'(32767);
  localparam logic [DivCntW-1:0]     DivLast  = DivCntW'(DivNW - 1);
  localparam logic [DivCntW-1:0]     SqrtLast = DivCntW'(31);
  localparam logic [7:0]             MaxBones = 8'd64;

  // Sequencer states, one-hot.
  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_PRD    = 20'h00002,
    S_PMUL   = 20'h00004,
    S_PACC   = 20'h00008,
    S_WMUL   = 20'h00010,
    S_WACC   = 20'h00020,
    S_MSTART = 20'h00040,
    S_MDIV   = 20'h00080,
    S_MFIN   = 20'h00100,
    S_TMULP  = 20'h00200,
    S_TACCP  = 20'h00400,
    S_TMULN  = 20'h00800,
    S_TACCN  = 20'h01000,
    S_NSHIFT = 20'h02000,
    S_NSQM   = 20'h04000,
    S_NSQA   = 20'h08000,
    S_NSQRT  = 20'h10000,
    S_NSTART = 20'h20000,
    S_NDIV   = 20'h40000,
    S_NFIN   = 20'h80000
  } state_e;

  typedef logic signed [AccW-1:0] acc_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Round a Q32.32 product half up to Q16.16.
  function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

endpackage

// ===== sv/lbs_if.sv =====
// Valid/ready channel interfaces of the skinning block: request, result, config.
// Does not depend on lbs_pkg; widths are fixed by the fields.
`timescale 1ns / 1ps

interface lbs_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [10:0]        table_address;
  logic signed [31:0] table_word;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic [31:0]        bone_ids;
  logic [63:0]        blend_weights;

  modport source (output valid, opcode, table_address, table_word, pos_x, pos_y, pos_z,
                  nrm_x, nrm_y, nrm_z, bone_ids, blend_weights, input ready);
  modport sink (input valid, opcode, table_address, table_word, pos_x, pos_y, pos_z,
                nrm_x, nrm_y, nrm_z, bone_ids, blend_weights, output ready);
endinterface

interface lbs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [15:0] out_nrm_x;
  logic signed [15:0] out_nrm_y;
  logic signed [15:0] out_nrm_z;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z,
                out_nrm_x, out_nrm_y, out_nrm_z, output ready);
endinterface

interface lbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/linear_blend_vertex_skinning.sv =====
// Four-influence linear blend skinning with a shared multiplier and divider.
// Depends on lbs_pkg and the channel interfaces in lbs_if.sv.
`timescale 1ns / 1ps

// Usage:
// A request on req_i either loads one matrix word (opcode 0) into the joint or
// inverse bind table, or skins one vertex (opcode 1). A load gives no result.
// A skin request gives one result on rsp_o.
// The register active_bones is written on cfg_i; write it only while idle.
// A skin request walks one shared 32x32 multiplier and one bit-serial divider
// under a sequencer: for each usable influence, 16 elements of a 4-term matrix
// product plus weighting; renormalisation with one division per element (an
// identity fill for the identity fallback); the transform; right shifts of the
// normal until each magnitude fits in 30 bits; a square root; and one division
// per normal component unless the length is zero. The divider gives one
// quotient bit per cycle. req_i is not ready while a vertex is in work. The
// result sits in an output register; the sequencer waits at the end of a
// vertex only if the previous result was not yet taken.
// Reset clears active_bones and the control state; table contents stay
// undefined until loaded.
module linear_blend_vertex_skinning (
  input  logic clk_i,
  input  logic rst_ni,
  lbs_req_if.sink   req_i,
  lbs_cfg_if.sink   cfg_i,
  lbs_rsp_if.source rsp_o
);

  // Control state.
  lbs_pkg::state_e state_q, state_d;
  logic [1:0] infl_q, infl_d;
  logic [1:0] c_q, c_d;
  logic [1:0] r_q, r_d;
  logic [1:0] k_q, k_d;
  logic [lbs_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic [6:0] active_q;

  // Payload state.
  logic signed [31:0] pos_q [3];
  logic signed [15:0] nrm_q [3];
  logic [31:0] bones_q;
  logic [63:0] weights_q;
  logic [3:0] used_q;
  logic [lbs_pkg::WsumW-1:0] wsum_q;
  lbs_pkg::acc_t s_q [16];
  lbs_pkg::acc_t acc_q;
  lbs_pkg::acc_t accp_q;
  lbs_pkg::acc_t vacc_q;
  logic [lbs_pkg::AccW-1:0] mag_q [3];
  logic [2:0] vneg_q;
  logic signed [31:0] res_pos_q [3];
  logic signed [15:0] res_nrm_q [2];
  logic signed [63:0] mul_q;
  logic [lbs_pkg::SqW-1:0] sq_q, sx_q, sr_q, sbit_q;
  logic [lbs_pkg::DivNW-1:0] div_n_q;
  logic [lbs_pkg::DivDW-1:0] div_r_q, div_d_q;
  logic div_neg_q;
  logic signed [31:0] opos_q [3];
  logic signed [15:0] onrm_q [3];

  // Tables.
  logic signed [31:0] jt_mem [1024];
  logic signed [31:0] ib_mem [1024];
  logic signed [31:0] jt_rd_q, ib_rd_q;

  // Handshakes.
  logic req_fire, skin_fire, load_fire, rsp_fire, finish;
  assign req_i.ready = (state_q == lbs_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign skin_fire   = req_fire && (req_i.opcode == lbs_pkg::OpSkin);
  assign load_fire   = req_fire && (req_i.opcode == lbs_pkg::OpLoad);
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign finish      = (state_q == lbs_pkg::S_NFIN) && (r_q == 2'd2) &&
                       (!out_valid_q || rsp_o.ready);

  // Influence selection from the incoming request.
  logic [3:0] used_in;
  logic [lbs_pkg::WsumW-1:0] wsum_in;
  always_comb begin
    logic [15:0] w;
    logic [7:0] b;
    wsum_in = '0;
    for (int i = 0; i < 4; i++) begin
      w = req_i.blend_weights[16*i +: 16];
      b = req_i.bone_ids[8*i +: 8];
      used_in[i] = (w != 16'd0) && !w[15] && (b < {1'b0, active_q}) &&
                   (b < lbs_pkg::MaxBones);
      if (used_in[i]) begin
        wsum_in = wsum_in + lbs_pkg::WsumW'(w);
      end
    end
  end

  // Current influence, table read addresses and blend element.
  logic [lbs_pkg::BoneW-1:0] bone;
  logic [14:0] wcur;
  logic [3:0] elem;
  assign bone = bones_q[{infl_q, 3'b000} +: lbs_pkg::BoneW];
  assign wcur = weights_q[{infl_q, 4'b0000} +: 15];
  assign elem = {c_q, r_q};

  // Table write on a load request and registered reads.
  always_ff @(posedge clk_i) begin
    if (load_fire && !req_i.table_address[10]) begin
      jt_mem[req_i.table_address[9:0]] <= req_i.table_word;
    end
    if (load_fire && req_i.table_address[10]) begin
      ib_mem[req_i.table_address[9:0]] <= req_i.table_word;
    end
    jt_rd_q <= jt_mem[{bone, k_q, r_q}];
    ib_rd_q <= ib_mem[{bone, c_q, k_q}];
  end

  // Blend matrix read port.
  logic [3:0] rd_idx;
  lbs_pkg::acc_t m_rd;
  assign rd_idx = (state_q == lbs_pkg::S_TACCP) ? {2'b11, r_q} : elem;
  assign m_rd   = s_q[rd_idx];

  // Shared multiplier operand select.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_d;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      lbs_pkg::S_PMUL: begin
        mul_a = jt_rd_q;
        mul_b = ib_rd_q;
      end
      lbs_pkg::S_WMUL: begin
        mul_a = lbs_pkg::sat32(64'(acc_q));
        mul_b = $signed({17'd0, wcur});
      end
      lbs_pkg::S_TMULP: begin
        mul_a = m_rd[31:0];
        mul_b = pos_q[c_q];
      end
      lbs_pkg::S_TMULN: begin
        mul_a = m_rd[31:0];
        mul_b = 32'(nrm_q[c_q]);
      end
      lbs_pkg::S_NSQM: begin
        mul_a = $signed(mag_q[r_q][31:0]);
        mul_b = $signed(mag_q[r_q][31:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_d = 64'(mul_a) * 64'(mul_b);
  end

  // Divider step, square-root step and helper values.
  logic [lbs_pkg::DivDW:0] rem_sh;
  logic div_ge;
  logic [lbs_pkg::DivDW:0] rem_new;
  logic near_one, ident, big, len_zero;
  logic [lbs_pkg::WsumW-1:0] divisor;
  logic [lbs_pkg::SqW-1:0] sq_t;
  logic sq_ge;
  logic [31:0] len;
  lbs_pkg::acc_t smag, vnew, accp_new;
  logic [63:0] qsigned;
  logic [14:0] qn;
  logic signed [15:0] nrm_val;

  always_comb begin
    rem_sh   = {div_r_q, div_n_q[lbs_pkg::DivNW-1]};
    div_ge   = rem_sh >= {1'b0, div_d_q};
    rem_new  = div_ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;
    near_one = (wsum_q >= lbs_pkg::NearLo) && (wsum_q <= lbs_pkg::NearHi);
    ident    = (wsum_q == '0);
    divisor  = near_one ? lbs_pkg::OneQ15 : wsum_q;
    smag     = m_rd[lbs_pkg::AccW-1] ? -m_rd : m_rd;
    big      = (|mag_q[0][lbs_pkg::AccW-1:30]) || (|mag_q[1][lbs_pkg::AccW-1:30]) ||
               (|mag_q[2][lbs_pkg::AccW-1:30]);
    sq_t     = sr_q + sbit_q;
    sq_ge    = sx_q >= sq_t;
    len      = sr_q[31:0];
    len_zero = (len == 32'd0);
    accp_new = ((c_q == 2'd0) ? m_rd : accp_q) +
               lbs_pkg::AccW'(lbs_pkg::round_q16(mul_q));
    vnew     = ((c_q == 2'd0) ? lbs_pkg::acc_t'(0) : vacc_q) + mul_q[lbs_pkg::AccW-1:0];
    qsigned  = div_neg_q ? -64'(div_n_q) : 64'(div_n_q);
    if (len_zero) begin
      qn = '0;
    end else if (div_n_q > lbs_pkg::NrmCap) begin
      qn = 15'h7FFF;
    end else begin
      qn = div_n_q[14:0];
    end
    nrm_val = vneg_q[r_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  end

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    infl_d      = infl_q;
    c_d         = c_q;
    r_d         = r_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (rsp_fire) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      lbs_pkg::S_IDLE: begin
        if (skin_fire) begin
          state_d = lbs_pkg::S_PRD;
          infl_d  = '0;
          c_d     = '0;
          r_d     = '0;
          k_d     = '0;
        end
      end
      lbs_pkg::S_PRD: begin
        if (!used_q[infl_q]) begin
          if (infl_q == 2'd3) begin
            state_d = lbs_pkg::S_MSTART;
          end else begin
            infl_d = infl_q + 2'd1;
          end
        end else begin
          state_d = lbs_pkg::S_PMUL;
        end
      end
      lbs_pkg::S_PMUL: begin
        state_d = lbs_pkg::S_PACC;
      end
      lbs_pkg::S_PACC: begin
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd3) ? lbs_pkg::S_WMUL : lbs_pkg::S_PRD;
      end
      lbs_pkg::S_WMUL: begin
        state_d = lbs_pkg::S_WACC;
      end
      lbs_pkg::S_WACC: begin
        {c_d, r_d} = elem + 4'd1;
        if (elem == 4'd15) begin
          if (infl_q == 2'd3) begin
            state_d = lbs_pkg::S_MSTART;
          end else begin
            infl_d  = infl_q + 2'd1;
            state_d = lbs_pkg::S_PRD;
          end
        end else begin
          state_d = lbs_pkg::S_PRD;
        end
      end
      lbs_pkg::S_MSTART: begin
        if (ident) begin
          {c_d, r_d} = elem + 4'd1;
          if (elem == 4'd15) begin
            state_d = lbs_pkg::S_TMULP;
          end
        end else begin
          cnt_d   = '0;
          state_d = lbs_pkg::S_MDIV;
        end
      end
      lbs_pkg::S_MDIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lbs_pkg::DivLast) begin
          state_d = lbs_pkg::S_MFIN;
        end
      end
      lbs_pkg::S_MFIN: begin
        {c_d, r_d} = elem + 4'd1;
        state_d = (elem == 4'd15) ? lbs_pkg::S_TMULP : lbs_pkg::S_MSTART;
      end
      lbs_pkg::S_TMULP: begin
        state_d = lbs_pkg::S_TACCP;
      end
      lbs_pkg::S_TACCP: begin
        state_d = lbs_pkg::S_TMULN;
      end
      lbs_pkg::S_TMULN: begin
        state_d = lbs_pkg::S_TACCN;
      end
      lbs_pkg::S_TACCN: begin
        state_d = lbs_pkg::S_TMULP;
        if (c_q == 2'd2) begin
          c_d = '0;
          if (r_q == 2'd2) begin
            r_d     = '0;
            state_d = lbs_pkg::S_NSHIFT;
          end else begin
            r_d = r_q + 2'd1;
          end
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      lbs_pkg::S_NSHIFT: begin
        if (!big) begin
          r_d     = '0;
          state_d = lbs_pkg::S_NSQM;
        end
      end
      lbs_pkg::S_NSQM: begin
        state_d = lbs_pkg::S_NSQA;
      end
      lbs_pkg::S_NSQA: begin
        if (r_q == 2'd2) begin
          cnt_d   = '0;
          state_d = lbs_pkg::S_NSQRT;
        end else begin
          r_d     = r_q + 2'd1;
          state_d = lbs_pkg::S_NSQM;
        end
      end
      lbs_pkg::S_NSQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lbs_pkg::SqrtLast) begin
          r_d     = '0;
          state_d = lbs_pkg::S_NSTART;
        end
      end
      lbs_pkg::S_NSTART: begin
        cnt_d   = '0;
        state_d = len_zero ? lbs_pkg::S_NFIN : lbs_pkg::S_NDIV;
      end
      lbs_pkg::S_NDIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lbs_pkg::DivLast) begin
          state_d = lbs_pkg::S_NFIN;
        end
      end
      lbs_pkg::S_NFIN: begin
        if (r_q != 2'd2) begin
          r_d     = r_q + 2'd1;
          state_d = lbs_pkg::S_NSTART;
        end else if (finish) begin
          out_valid_d = 1'b1;
          state_d     = lbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lbs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbs_pkg::S_IDLE;
      infl_q      <= '0;
      c_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      active_q    <= '0;
    end else begin
      state_q     <= state_d;
      infl_q      <= infl_d;
      c_q         <= c_d;
      r_q         <= r_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        active_q <= cfg_i.data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    case (state_q)
      lbs_pkg::S_IDLE: begin
        if (skin_fire) begin
          pos_q[0]  <= req_i.pos_x;
          pos_q[1]  <= req_i.pos_y;
          pos_q[2]  <= req_i.pos_z;
          nrm_q[0]  <= req_i.nrm_x;
          nrm_q[1]  <= req_i.nrm_y;
          nrm_q[2]  <= req_i.nrm_z;
          bones_q   <= req_i.bone_ids;
          weights_q <= req_i.blend_weights;
          used_q    <= used_in;
          wsum_q    <= wsum_in;
          acc_q     <= '0;
          for (int e = 0; e < 16; e++) begin
            s_q[e] <= '0;
          end
        end
      end
      lbs_pkg::S_PACC: begin
        acc_q <= ((k_q == 2'd0) ? lbs_pkg::acc_t'(0) : acc_q) +
                 lbs_pkg::AccW'(lbs_pkg::round_q16(mul_q));
      end
      lbs_pkg::S_WACC: begin
        s_q[elem] <= m_rd + mul_q[lbs_pkg::AccW-1:0];
      end
      lbs_pkg::S_MSTART: begin
        if (ident) begin
          s_q[elem] <= (c_q == r_q) ? lbs_pkg::OneQ16 : lbs_pkg::acc_t'(0);
        end else begin
          div_n_q   <= smag + lbs_pkg::DivNW'(divisor >> 1);
          div_d_q   <= lbs_pkg::DivDW'(divisor);
          div_r_q   <= '0;
          div_neg_q <= m_rd[lbs_pkg::AccW-1];
        end
      end
      lbs_pkg::S_MDIV, lbs_pkg::S_NDIV: begin
        div_r_q <= rem_new[lbs_pkg::DivDW-1:0];
        div_n_q <= {div_n_q[lbs_pkg::DivNW-2:0], div_ge};
      end
      lbs_pkg::S_MFIN: begin
        s_q[elem] <= lbs_pkg::AccW'(lbs_pkg::sat32($signed(qsigned)));
      end
      lbs_pkg::S_TACCP: begin
        accp_q <= accp_new;
      end
      lbs_pkg::S_TACCN: begin
        vacc_q <= vnew;
        if (c_q == 2'd2) begin
          res_pos_q[r_q] <= lbs_pkg::sat32(64'(accp_q));
          vneg_q[r_q]    <= vnew[lbs_pkg::AccW-1];
          mag_q[r_q]     <= vnew[lbs_pkg::AccW-1] ? -vnew : vnew;
        end
      end
      lbs_pkg::S_NSHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end
      end
      lbs_pkg::S_NSQA: begin
        if (r_q == 2'd2) begin
          sx_q   <= sq_q + mul_q[lbs_pkg::SqW-1:0];
          sr_q   <= '0;
          sbit_q <= lbs_pkg::SqW'(1) << 62;
        end
        sq_q <= ((r_q == 2'd0) ? '0 : sq_q) + mul_q[lbs_pkg::SqW-1:0];
      end
      lbs_pkg::S_NSQRT: begin
        if (sq_ge) begin
          sx_q <= sx_q - sq_t;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      lbs_pkg::S_NSTART: begin
        div_n_q <= {mag_q[r_q][lbs_pkg::DivNW-15:0], 14'd0} +
                   lbs_pkg::DivNW'(len >> 1);
        div_d_q <= len;
        div_r_q <= '0;
      end
      lbs_pkg::S_NFIN: begin
        if (r_q != 2'd2) begin
          res_nrm_q[r_q[0]] <= nrm_val;
        end else if (finish) begin
          opos_q[0] <= res_pos_q[0];
          opos_q[1] <= res_pos_q[1];
          opos_q[2] <= res_pos_q[2];
          onrm_q[0] <= res_nrm_q[0];
          onrm_q[1] <= res_nrm_q[1];
          onrm_q[2] <= nrm_val;
        end
      end
      default: begin
      end
    endcase
  end

  // Result channel.
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_pos_x = opos_q[0];
  assign rsp_o.out_pos_y = opos_q[1];
  assign rsp_o.out_pos_z = opos_q[2];
  assign rsp_o.out_nrm_x = onrm_q[0];
  assign rsp_o.out_nrm_y = onrm_q[1];
  assign rsp_o.out_nrm_z = onrm_q[2];

endmodule

// ===== tb/linear_blend_vertex_skinning_tb.sv =====
// Self-checking testbench for linear_blend_vertex_skinning: table loads, skin requests
// and active_bones writes, checked against an in-bench skinning predictor.
// Depends on lbs_pkg and the channel interfaces in sv/lbs_if.sv.
`timescale 1ns / 1ps

module linear_blend_vertex_skinning_tb;

  localparam int WatchLimit = 20000;
  localparam int MaxReports = 10;

  typedef struct {
    logic               opcode;
    logic [10:0]        table_address;
    logic signed [31:0] table_word;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
    logic [31:0]        bone_ids;
    logic [63:0]        blend_weights;
  } vtx_req_t;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] nrm_x, nrm_y, nrm_z;
  } vtx_out_t;

  typedef struct {
    vtx_req_t req;
    bit       typed;
    vtx_out_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  lbs_req_if req ();
  lbs_cfg_if cfg ();
  lbs_rsp_if rsp ();

  linear_blend_vertex_skinning u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .cfg_i (cfg),
    .rsp_o (rsp)
  );

  // Predictor state: both matrix tables, which words were written, and the register.
  int          joint_mem   [1024];
  int          bind_mem    [1024];
  bit          joint_seen  [1024];
  bit          bind_seen   [1024];
  logic [6:0]  bone_count;

  vtx_out_t    pending_vertices[$];
  int          mismatches;
  int          vertices_checked;
  int          loads_sent;
  int          idle_cycles;
  bit          quiet_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint q16_round(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint div_nearest(input longint s, input longint d);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-s) : s;
    q = (mag + d / 2) / d;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Blend the usable influences, then transform the position and the normal.
  function automatic vtx_out_t skin_vertex(input vtx_req_t it);
    longint s[16];
    longint m[16];
    longint p[3];
    longint op[3];
    longint n[3];
    longint v[3];
    longint acc;
    longint wsum;
    longint dev;
    longint dvs;
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    longint o;
    int limit;
    int w;
    int b;
    int base;
    int sh;
    vtx_out_t res;
    limit = (bone_count < 64) ? int'(bone_count) : 64;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    n[0] = it.nrm_x; n[1] = it.nrm_y; n[2] = it.nrm_z;
    foreach (s[k]) s[k] = 0;
    wsum = 0;
    for (int i = 0; i < 4; i++) begin
      w = int'(it.blend_weights[16*i +: 16]);
      b = int'(it.bone_ids[8*i +: 8]);
      if (w == 0 || w[15] || b >= limit) continue;
      base = (b % 64) * 16;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) begin
            acc += q16_round(longint'(joint_mem[base + k*4 + r]) *
                             longint'(bind_mem[base + c*4 + k]));
          end
          s[c*4 + r] += clip32(acc) * w;
        end
      end
      wsum += w;
    end
    // No usable weight falls back to identity; near-unit totals skip renormalizing.
    if (wsum == 0) begin
      foreach (m[k]) m[k] = (k % 5 == 0) ? 64'sd65536 : 64'sd0;
    end else begin
      dev = wsum - 32768;
      dvs = (dev <= 3 && dev >= -3) ? 64'sd32768 : wsum;
      foreach (m[k]) m[k] = clip32(div_nearest(s[k], dvs));
    end
    mx = 0;
    for (int r = 0; r < 3; r++) begin
      acc = m[12 + r];
      v[r] = 0;
      for (int c = 0; c < 3; c++) begin
        acc += q16_round(m[c*4 + r] * p[c]);
        v[r] += m[c*4 + r] * n[c];
      end
      op[r] = clip32(acc);
      mag[r] = (v[r] < 0) ? longint'(-v[r]) : v[r];
      if (mag[r] > mx) mx = mag[r];
    end
    res.pos_x = op[0][31:0];
    res.pos_y = op[1][31:0];
    res.pos_z = op[2][31:0];
    // Scale the normal to unit length; a zero-length normal stays zero.
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    sq = 0;
    for (int r = 0; r < 3; r++) begin
      mag[r] >>= sh;
      sq += mag[r] * mag[r];
    end
    len = int_sqrt(sq);
    for (int r = 0; r < 3; r++) begin
      q = 0;
      if (len != 0) begin
        q = (mag[r] * 16384 + len / 2) / len;
        if (q > 32767) q = 32767;
      end
      o = (v[r] < 0) ? -longint'(q) : longint'(q);
      n[r] = o;
    end
    res.nrm_x = n[0][15:0];
    res.nrm_y = n[1][15:0];
    res.nrm_z = n[2][15:0];
    return res;
  endfunction

  // Apply an accepted request to the predictor state.
  function automatic void absorb_request(input vtx_req_t it, input bit typed,
                                         input vtx_out_t want);
    int a;
    if (it.opcode == lbs_pkg::OpLoad) begin
      a = int'(it.table_address[9:0]);
      if (it.table_address[10]) begin
        bind_mem[a] = it.table_word;
        bind_seen[a] = 1'b1;
      end else begin
        joint_mem[a] = it.table_word;
        joint_seen[a] = 1'b1;
      end
      loads_sent++;
    end else begin
      pending_vertices.push_back(typed ? want : skin_vertex(it));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one request and wait for its handshake.
  task automatic send_request(input vtx_req_t it, input bit typed, input vtx_out_t want);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req.valid         <= 1'b1;
    req.opcode        <= it.opcode;
    req.table_address <= it.table_address;
    req.table_word    <= it.table_word;
    req.pos_x         <= it.pos_x;
    req.pos_y         <= it.pos_y;
    req.pos_z         <= it.pos_z;
    req.nrm_x         <= it.nrm_x;
    req.nrm_y         <= it.nrm_y;
    req.nrm_z         <= it.nrm_z;
    req.bone_ids      <= it.bone_ids;
    req.blend_weights <= it.blend_weights;
    do @(posedge clk_i); while (!req.ready);
    absorb_request(it, typed, want);
  endtask

  // Write active_bones once the block has drained.
  task automatic write_bone_count(input logic [6:0] val);
    req.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    bone_count = val;
    cfg.valid <= 1'b0;
  endtask

  function automatic vtx_req_t noise_fields();
    vtx_req_t it;
    logic [31:0] rnd;
    it.opcode        = lbs_pkg::OpSkin;
    rnd              = $urandom();
    it.table_address = rnd[10:0];
    it.table_word    = $urandom();
    it.pos_x         = $urandom();
    it.pos_y         = $urandom();
    it.pos_z         = $urandom();
    rnd              = $urandom();
    it.nrm_x         = rnd[15:0];
    it.nrm_y         = rnd[31:16];
    rnd              = $urandom();
    it.nrm_z         = rnd[15:0];
    it.bone_ids      = $urandom();
    it.blend_weights = {$urandom(), $urandom()};
    return it;
  endfunction

  function automatic int signed_range(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  // One matrix word in a given style: mostly near identity, some scaled or wild.
  function automatic int matrix_word(input int style, input int e);
    int col;
    int row;
    col = e / 4;
    row = e % 4;
    if (style == 0) return $urandom();
    if (row == 3) return (col == 3) ? 65536 : 0;
    if (col == 3) return signed_range(1 << 22);
    if (col == row) return (style == 1) ? (1 << 24) + signed_range(1 << 20)
                                        : 65536 + signed_range(8192);
    return signed_range(20000);
  endfunction

  // Load both matrices of one bone, word by word.
  task automatic load_bone(input int bone);
    vtx_req_t it;
    int style;
    for (int t = 0; t < 2; t++) begin
      style = $urandom_range(0, 9);
      for (int e = 0; e < 16; e++) begin
        it = noise_fields();
        it.opcode = lbs_pkg::OpLoad;
        it.table_address = {t[0], bone[5:0], e[3:0]};
        it.table_word = matrix_word(style, e);
        send_request(it, 1'b0, '{default: '0});
      end
    end
  endtask

  function automatic bit bone_loaded(input int bone);
    for (int e = 0; e < 16; e++) begin
      if (!joint_seen[bone*16 + e] || !bind_seen[bone*16 + e]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // A skin request whose usable influences touch only fully loaded bones.
  function automatic vtx_req_t random_skin();
    vtx_req_t it;
    int limit;
    int ready_bones[$];
    int k;
    int total;
    int left;
    int lo;
    int hi;
    int w;
    int mode;
    int pick;
    it = noise_fields();
    limit = (bone_count < 64) ? int'(bone_count) : 64;
    for (int b = 0; b < limit; b++) if (bone_loaded(b)) ready_bones.push_back(b);
    if ($urandom_range(0, 3) != 0) begin
      it.pos_x = signed_range(1 << 24);
      it.pos_y = signed_range(1 << 24);
      it.pos_z = signed_range(1 << 24);
    end
    mode = $urandom_range(0, 9);
    k = (ready_bones.size() == 0 || mode == 9) ? 0 : $urandom_range(1, 4);
    // Unit total, near-unit total, or an arbitrary total that usually needs renormalizing.
    if (mode < 5) total = 32768 + $urandom_range(0, 6) - 3;
    else total = $urandom_range(k, k * 32767);
    if (k == 1 && total > 32767) total = $urandom_range(32765, 32767);
    left = total;
    for (int i = 0; i < 4; i++) begin
      if (i < k) begin
        lo = left - 32767 * (k - 1 - i);
        if (lo < 1) lo = 1;
        hi = left - (k - 1 - i);
        if (hi > 32767) hi = 32767;
        w = (i == k - 1) ? left : $urandom_range(lo, hi);
        left -= w;
        it.blend_weights[16*i +: 16] = w[15:0];
        pick = ready_bones[$urandom_range(0, ready_bones.size() - 1)];
        it.bone_ids[8*i +: 8] = pick[7:0];
      end else begin
        // Skipped influence: zero weight, negative weight, or a bone past the count.
        case ($urandom_range(0, 2))
          0: it.blend_weights[16*i +: 16] = 16'h0000;
          1: begin
            w = $urandom_range(0, 32767);
            it.blend_weights[16*i +: 16] = 16'h8000 | w[15:0];
          end
          default: begin
            w = $urandom_range(1, 32767);
            it.blend_weights[16*i +: 16] = w[15:0];
            pick = $urandom_range(limit, 255);
            it.bone_ids[8*i +: 8] = pick[7:0];
          end
        endcase
      end
    end
    return it;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got, inout bit bad);
    if (want != got) begin
      if (mismatches < MaxReports) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
      bad = 1'b1;
    end
  endfunction

  // Result side: random stalls and a check of every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= quiet_mode || ($urandom_range(0, 99) < 70) ||
                   ($urandom_range(0, 9) == 0 && $urandom_range(0, 9) == 0);
    end
  end

  always @(posedge clk_i) begin
    vtx_out_t want;
    bit bad;
    if (rst_ni && rsp.valid && rsp.ready) begin
      bad = 1'b0;
      if (pending_vertices.size() == 0) begin
        if (mismatches < MaxReports) $display("%0t: result with no request waiting", $time);
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        compare_field("out_pos_x", want.pos_x, rsp.out_pos_x, bad);
        compare_field("out_pos_y", want.pos_y, rsp.out_pos_y, bad);
        compare_field("out_pos_z", want.pos_z, rsp.out_pos_z, bad);
        compare_field("out_nrm_x", want.nrm_x, rsp.out_nrm_x, bad);
        compare_field("out_nrm_y", want.nrm_y, rsp.out_nrm_y, bad);
        compare_field("out_nrm_z", want.nrm_z, rsp.out_nrm_z, bad);
        if (bad) mismatches++;
        vertices_checked++;
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or write.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", pending_vertices.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [6:0] settings[6];
    int limit;
    int nb;
    req.valid = 1'b0;
    req.opcode = lbs_pkg::OpLoad;
    req.table_address = '0;
    req.table_word = '0;
    req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
    req.nrm_x = '0; req.nrm_y = '0; req.nrm_z = '0;
    req.bone_ids = '0;
    req.blend_weights = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    quiet_mode = 1'b0;
    mismatches = 0;
    vertices_checked = 0;
    loads_sent = 0;
    idle_cycles = 0;
    bone_count = '0;
    foreach (joint_seen[a]) begin
      joint_seen[a] = 1'b0;
      bind_seen[a] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: with no active bones every skin blends to identity.
    write_bone_count(7'd0);
    row.req = noise_fields();
    row.typed = 1'b1;
    row.req.pos_x = 32'sh7FFFFFFF; row.req.pos_y = 32'sh80000000; row.req.pos_z = 0;
    row.req.nrm_x = 16'sd16384; row.req.nrm_y = 16'sd0; row.req.nrm_z = 16'sd0;
    row.req.bone_ids = 32'hFFFFFFFF; row.req.blend_weights = 64'h7FFF7FFF7FFF7FFF;
    row.want = '{32'sh7FFFFFFF, 32'sh80000000, 0, 16384, 0, 0};
    rows.push_back(row);
    row.req.pos_x = 1; row.req.pos_y = -1; row.req.pos_z = 32'sh12345678;
    row.req.nrm_x = 16'sd0; row.req.bone_ids = 0; row.req.blend_weights = 0;
    row.want = '{1, -1, 32'sh12345678, 0, 0, 0};
    rows.push_back(row);
    row.req.nrm_x = 16'sh8000; row.req.bone_ids = 32'h03020100;
    row.req.blend_weights = 64'h2000200020002000;
    row.want = '{1, -1, 32'sh12345678, -16384, 0, 0};
    rows.push_back(row);
    row.req.nrm_x = 16'sd0; row.req.nrm_y = 16'sd32767; row.req.blend_weights = '1;
    row.want = '{1, -1, 32'sh12345678, 0, 16384, 0};
    rows.push_back(row);
    row.req.nrm_y = 16'sd0; row.req.nrm_z = -16'sd1;
    row.req.table_address = '1; row.req.table_word = '1;
    row.want = '{1, -1, 32'sh12345678, 0, 0, -16384};
    rows.push_back(row);
    row.req.nrm_x = 16'sd3000; row.req.nrm_y = 16'sd4000; row.req.nrm_z = 16'sd0;
    row.want = '{1, -1, 32'sh12345678, 9830, 13107, 0};
    rows.push_back(row);
    row.req.nrm_x = 16'sd1; row.req.nrm_y = 16'sd1;
    row.want = '{1, -1, 32'sh12345678, 11585, 11585, 0};
    rows.push_back(row);
    // Loads at the address and word extremes, which give no result, then one more skin.
    row.typed = 1'b0;
    row.req.opcode = lbs_pkg::OpLoad;
    row.req.table_address = 11'h7FF; row.req.table_word = 32'sh7FFFFFFF;
    rows.push_back(row);
    row.req.table_address = 11'h000; row.req.table_word = 32'sh80000000;
    rows.push_back(row);
    row.req.table_address = 11'h400; row.req.table_word = 0;
    rows.push_back(row);
    row.req.opcode = lbs_pkg::OpSkin; row.req.pos_x = 32'sh80000000;
    row.req.pos_y = 32'sh7FFFFFFF; row.req.nrm_x = 16'sh8000; row.req.nrm_y = 16'sh8000;
    row.req.nrm_z = 16'sd32767;
    rows.push_back(row);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

    // Random part: each setting reloads a few bones, then mostly skins.
    settings = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd40, 7'd64};
    foreach (settings[ph]) begin
      quiet_mode = (ph == 2);
      write_bone_count(settings[ph]);
      limit = (bone_count < 64) ? int'(bone_count) : 64;
      nb = (ph == 0) ? 8 : 3;
      for (int i = 0; i < nb; i++) load_bone($urandom_range(0, limit - 1));
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          row.req = noise_fields();
          row.req.opcode = lbs_pkg::OpLoad;
          send_request(row.req, 1'b0, row.want);
        end else begin
          send_request(random_skin(), 1'b0, row.want);
        end
      end
    end
    req.valid <= 1'b0;
    quiet_mode = 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d table loads and %0d checked vertices over six bone counts,",
             loads_sent, vertices_checked);
    $display("including identity fallback, near-unit and renormalized blends");
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad results", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
